/* rtl/fgtg_pkg.sv */
// ----------------------------------------------------------------------------
// fgtg_pkg
// Shared constants for the gait trajectory generator: sizes, register indices,
// series coefficients, the sine polynomial and the degree-to-mrad factor.
// ----------------------------------------------------------------------------
`default_nettype none

package fgtg_pkg;

  localparam int HARMONICS          = 6;
  localparam int SINE_TABLE_ENTRIES = 1024;
  localparam int STEP_BITS          = 16;

  localparam int SINE_BITS = $clog2(SINE_TABLE_ENTRIES);
  localparam int HARM_W    = $clog2(HARMONICS + 1);
  localparam int MUL_W     = 34;
  localparam int PROD_W    = 2 * MUL_W;

  localparam logic [2:0] REG_START  = 3'd0;
  localparam logic [2:0] REG_HSTEPS = 3'd1;
  localparam logic [2:0] REG_WSTEPS = 3'd2;
  localparam logic [2:0] REG_WINC   = 3'd3;
  localparam logic [2:0] REG_HINC   = 3'd4;
  localparam logic [2:0] REG_LOFF   = 3'd5;
  localparam logic [2:0] REG_OFFSET = 3'd6;

  // Series coefficients, degrees in Q16.
  localparam logic signed [22:0] COEF_COS [0:8] = '{
    23'sd2666660, 23'sd1521746, -23'sd294060, 23'sd26182, 23'sd46183,
    23'sd70648, -23'sd17904, 23'sd0, 23'sd0
  };
  localparam logic signed [22:0] COEF_SIN [0:8] = '{
    23'sd0, -23'sd566886, 23'sd218759, 23'sd91030, 23'sd52357,
    23'sd22413, 23'sd4388, 23'sd0, 23'sd0
  };

  localparam logic signed [31:0] POLY_SEED = 32'sd172272;
  localparam logic signed [31:0] POLY [0:3] = '{
    -32'sd5026995, 32'sd85569306, -32'sd693598668, 32'sd1686629713
  };

  localparam logic signed [MUL_W-1:0] MRAD_PER_DEG_Q16 = 34'sd1143819;

endpackage

`default_nettype wire

/* rtl/fgtg_mul.sv */
// ----------------------------------------------------------------------------
// fgtg_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module fgtg_mul (
  input  wire logic                              clk,
  input  wire logic signed [fgtg_pkg::MUL_W-1:0] a,
  input  wire logic signed [fgtg_pkg::MUL_W-1:0] b,
  output logic signed [fgtg_pkg::PROD_W-1:0]     p
);
  import fgtg_pkg::*;

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

`default_nettype wire

/* rtl/fourier_gait_trajectory_generator.sv */
// ----------------------------------------------------------------------------
// fourier_gait_trajectory_generator
// Two-joint gait trajectory: raised-cosine homing, then a harmonic series.
// ----------------------------------------------------------------------------
//  channel   direction  payload
//  s_*       in         tdata[0] restart
//  m_*       out        tdata target_mrad, step_index; tuser joint, stage; tlast
//  cfg_*     in         register index and write data
//
//  The one shared multiplier sets the pace: a sine takes six products, a joint
//  sums twelve sine terms, and homing adds a cosine for the blend weight.
//  The block takes a new tick only once both results of the last one are out.
//  Reset (rst, synchronous) returns to homing step 0 with default registers.
//  A stalled output holds the sequencer until the result is transferred.
// ----------------------------------------------------------------------------
`default_nettype none

module fourier_gait_trajectory_generator (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [0] restart
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // [15:0] target_mrad, [31:16] step_index
  output logic [1:0]       m_tuser,   // [0] joint, [1] stage
  output logic             m_tlast,
  input  wire logic        cfg_wen,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  import fgtg_pkg::*;

  localparam int CMP_W = (STEP_BITS > 16) ? STEP_BITS : 16;
  localparam logic [31:0] PHASE_MASK = ~(32'hFFFF_FFFF >> SINE_BITS);

  typedef enum logic [1:0] {ST_HOMING, ST_WALKING, ST_DONE} stage_t;
  typedef enum logic [4:0] {
    IDLE, J_START, S_PREP, SIN_SQ, SIN_SQW, SIN_MUL, SIN_ACC, SIN_LAST, SIN_FIN,
    TERM_MUL, TERM_ACC, K_HI, K_HIW, K_LO, K_LOW, W_DONE, D_HI, D_HIW, D_LO,
    D_LOW, FINAL, OUT_WAIT
  } state_t;

  // Configuration registers.
  logic signed [13:0] start_pos;
  logic [15:0]        homing_steps;
  logic [15:0]        walk_steps;
  logic [31:0]        walk_inc;
  logic [31:0]        homing_inc;
  logic [31:0]        left_off;
  logic signed [8:0]  offset_deg;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_pos    <= '0;
      homing_steps <= 16'd2500;
      walk_steps   <= 16'd8359;
      walk_inc     <= 32'd2568826;
      homing_inc   <= 32'd858993;
      left_off     <= 32'h8000_0000;
      offset_deg   <= 9'sd23;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_START:  start_pos    <= cfg_data[13:0];
        REG_HSTEPS: homing_steps <= cfg_data[15:0];
        REG_WSTEPS: walk_steps   <= cfg_data[15:0];
        REG_WINC:   walk_inc     <= cfg_data;
        REG_HINC:   homing_inc   <= cfg_data;
        REG_LOFF:   left_off     <= cfg_data;
        REG_OFFSET: offset_deg   <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  state_t                 state;
  stage_t                 stage;
  logic [STEP_BITS-1:0]   step_count;
  logic [31:0]            walk_phase;
  logic [31:0]            homing_phase;
  logic                   joint;
  logic                   for_w;
  logic [31:0]            ph;
  logic [31:0]            hp;
  logic [HARM_W-1:0]      h;
  logic                   cs;
  logic [1:0]             quad;
  logic [30:0]            x;
  logic [30:0]            x2;
  logic signed [31:0]     hacc;
  logic [1:0]             k;
  logic signed [16:0]     sq;
  logic signed [63:0]     acc;
  logic signed [63:0]     tmp;
  logic signed [47:0]     q24;

  logic signed [MUL_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic [16:0]              w_val;

  fgtg_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));

  always_comb begin
    // Blend weight 32768 + cos, 0..65536, kept unsigned in 17 bits.
    w_val = 17'd32768 + $unsigned(sq);
    mul_a = '0;
    mul_b = '0;
    case (state)
      SIN_SQ:   begin mul_a = MUL_W'(x);    mul_b = MUL_W'(x);  end
      SIN_MUL:  begin mul_a = MUL_W'(hacc); mul_b = MUL_W'(x2); end
      SIN_LAST: begin mul_a = MUL_W'(hacc); mul_b = MUL_W'(x);  end
      TERM_MUL: begin
        mul_a = MUL_W'(cs ? COEF_SIN[{1'b0, h}] : COEF_COS[{1'b0, h}]);
        mul_b = MUL_W'(sq);
      end
      K_HI:     begin mul_a = acc[24+MUL_W-1:24];     mul_b = MRAD_PER_DEG_Q16; end
      K_LO:     begin mul_a = MUL_W'({1'b0, acc[23:0]}); mul_b = MRAD_PER_DEG_Q16; end
      D_HI:     begin mul_a = acc[24+MUL_W-1:24];     mul_b = MUL_W'(w_val); end
      D_LO:     begin mul_a = MUL_W'({1'b0, acc[23:0]}); mul_b = MUL_W'(w_val); end
      default: ;
    endcase
  end

  logic [31:0]        sine_phase;
  logic signed [37:0] s_val;
  logic signed [16:0] q_val;
  logic signed [47:0] rnd;
  logic signed [23:0] tr_val;
  logic               step_end;

  always_comb begin
    if (for_w) sine_phase = (homing_phase + 32'h4000_0000) & PHASE_MASK;
    else       sine_phase = (hp + (cs ? 32'h0 : 32'h4000_0000)) & PHASE_MASK;
    s_val = 38'(mul_p >>> 30);
    q_val = 17'((s_val + 38'sd16384) >>> 15);
    // Truncate toward zero: bias negative values before the shift.
    rnd    = q24 + ((q24 < 0) ? 48'sd16777215 : 48'sd0);
    tr_val = 24'(rnd >>> 24);
    if (stage == ST_HOMING)
      step_end = (CMP_W'(step_count) >= CMP_W'(homing_steps));
    else
      step_end = (CMP_W'(step_count) >= CMP_W'(walk_steps));
    if (step_count == {STEP_BITS{1'b1}}) step_end = 1'b1;
  end

  assign s_tready = (state == IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      stage        <= ST_HOMING;
      step_count   <= '0;
      walk_phase   <= '0;
      homing_phase <= '0;
      m_tvalid     <= 1'b0;
      joint        <= 1'b0;
      for_w        <= 1'b0;
    end else begin
      case (state)
        IDLE: begin
          if (s_tvalid) begin
            joint <= 1'b0;
            for_w <= 1'b0;
            if (s_tdata[0]) begin
              stage        <= ST_HOMING;
              step_count   <= '0;
              walk_phase   <= '0;
              homing_phase <= '0;
              state        <= J_START;
            end else if (stage != ST_DONE) begin
              state <= J_START;
            end
          end
        end
        J_START: begin
          ph  <= ((stage == ST_WALKING) ? walk_phase : 32'h0) - (joint ? left_off : 32'h0);
          hp  <= ((stage == ST_WALKING) ? walk_phase : 32'h0) - (joint ? left_off : 32'h0);
          h   <= HARM_W'(1);
          cs  <= 1'b0;
          acc <= (64'(COEF_COS[0]) <<< 15) - (64'(offset_deg) <<< 31);
          state <= S_PREP;
        end
        S_PREP: begin
          quad  <= sine_phase[31:30];
          x     <= sine_phase[30] ? (31'h4000_0000 - {1'b0, sine_phase[29:0]})
                                  : {1'b0, sine_phase[29:0]};
          state <= SIN_SQ;
        end
        SIN_SQ: state <= SIN_SQW;
        SIN_SQW: begin
          x2    <= mul_p[60:30];
          hacc  <= POLY_SEED;
          k     <= 2'd0;
          state <= SIN_MUL;
        end
        SIN_MUL: state <= SIN_ACC;
        SIN_ACC: begin
          hacc <= POLY[k] + 32'(mul_p >>> 30);
          if (k == 2'd3) begin
            state <= SIN_LAST;
          end else begin
            k     <= k + 2'd1;
            state <= SIN_MUL;
          end
        end
        SIN_LAST: state <= SIN_FIN;
        SIN_FIN: begin
          sq    <= quad[1] ? -q_val : q_val;
          state <= for_w ? W_DONE : TERM_MUL;
        end
        TERM_MUL: state <= TERM_ACC;
        TERM_ACC: begin
          acc <= acc + 64'(mul_p);
          if (!cs) begin
            cs    <= 1'b1;
            state <= S_PREP;
          end else begin
            cs <= 1'b0;
            if (h == HARM_W'(HARMONICS)) begin
              state <= K_HI;
            end else begin
              h     <= h + HARM_W'(1);
              hp    <= hp + ph;
              state <= S_PREP;
            end
          end
        end
        K_HI: state <= K_HIW;
        K_HIW: begin
          tmp   <= 64'(mul_p) <<< 24;
          state <= K_LO;
        end
        K_LO: state <= K_LOW;
        K_LOW: begin
          q24 <= 48'((tmp + 64'(mul_p)) >>> 23);
          if (stage == ST_HOMING) begin
            for_w <= 1'b1;
            state <= S_PREP;
          end else begin
            state <= FINAL;
          end
        end
        W_DONE: begin
          // Blend: tf + floor((start - tf) * w / 2^16), done as one sum.
          acc   <= (64'(start_pos) <<< 24) - 64'(q24);
          tmp   <= 64'(q24) <<< 16;
          state <= D_HI;
        end
        D_HI: state <= D_HIW;
        D_HIW: begin
          tmp   <= tmp + (64'(mul_p) <<< 24);
          state <= D_LO;
        end
        D_LO: state <= D_LOW;
        D_LOW: begin
          q24   <= 48'((tmp + 64'(mul_p)) >>> 16);
          state <= FINAL;
        end
        FINAL: begin
          if (tr_val > 24'sd32767)       m_tdata[15:0] <= 16'h7FFF;
          else if (tr_val < -24'sd32768) m_tdata[15:0] <= 16'h8000;
          else                           m_tdata[15:0] <= tr_val[15:0];
          m_tdata[31:16] <= 16'(step_count);
          m_tuser        <= {stage[0], joint};
          m_tlast        <= joint;
          m_tvalid       <= 1'b1;
          state          <= OUT_WAIT;
        end
        OUT_WAIT: begin
          if (m_tready) begin
            m_tvalid <= 1'b0;
            if (!joint) begin
              joint <= 1'b1;
              for_w <= 1'b0;
              state <= J_START;
            end else begin
              if (step_end) begin
                stage        <= (stage == ST_HOMING) ? ST_WALKING : ST_DONE;
                step_count   <= '0;
                walk_phase   <= '0;
                homing_phase <= '0;
              end else begin
                step_count <= step_count + STEP_BITS'(1);
                if (stage == ST_HOMING) homing_phase <= homing_phase + homing_inc;
                else                    walk_phase   <= walk_phase + walk_inc;
              end
              state <= IDLE;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* sim/fourier_gait_trajectory_generator_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fourier_gait_trajectory_generator_tb
// Drives restart/tick transfers through the trajectory generator under several
// register settings and flow-control patterns. A scoreboard mirrors the homing
// blend and the harmonic series and checks every output transfer in order.
// ----------------------------------------------------------------------------

module fourier_gait_trajectory_generator_tb;
  import fgtg_pkg::*;

  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam int HOLD_CYCLES = 3000;
  localparam int IDLE_LIMIT  = 20000;
  localparam int SETTLE      = 1000;

  typedef enum logic [1:0] {GAIT_HOMING = 2'd0, GAIT_WALKING = 2'd1, GAIT_DONE = 2'd2}
    gait_stage_t;

  typedef struct {
    logic               joint;
    logic signed [15:0] target_mrad;
    logic               stage;
    logic [15:0]        step_index;
    logic               last;
  } joint_cmd_t;

  class trajectory_scoreboard;
    logic signed [13:0] start_mrad;
    logic [15:0]        homing_last, walk_last;
    logic [31:0]        walk_inc, homing_inc, left_lag;
    logic signed [8:0]  offset_deg;
    gait_stage_t        stage;
    logic [15:0]        step_count;
    logic [31:0]        walk_phase, homing_phase;
    joint_cmd_t         pending_cmds[$];
    int                 errors;

    function void reset_state();
      start_mrad = 0; homing_last = 2500; walk_last = 8359;
      walk_inc = 2568826; homing_inc = 858993; left_lag = 32'h8000_0000;
      offset_deg = 23;
      stage = GAIT_HOMING; step_count = 0; walk_phase = 0; homing_phase = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        REG_START:  start_mrad = val[13:0];
        REG_HSTEPS: homing_last = val[15:0];
        REG_WSTEPS: walk_last = val[15:0];
        REG_WINC:   walk_inc = val;
        REG_HINC:   homing_inc = val;
        REG_LOFF:   left_lag = val;
        REG_OFFSET: offset_deg = val[8:0];
        default: ;
      endcase
    endfunction

    // Polynomial sine: the phase is snapped down to the start of its table slot.
    function longint sine_q15(logic [31:0] p);
      logic [31:0] ph;
      longint x, x2, acc, s, q;
      ph = {p[31:32-SINE_BITS], {(32-SINE_BITS){1'b0}}};
      x = longint'(ph[29:0]);
      if (ph[30]) x = 64'sh4000_0000 - x;
      x2 = (x * x) >>> 30;
      acc = 172272;
      acc = -5026995 + ((acc * x2) >>> 30);
      acc = 85569306 + ((acc * x2) >>> 30);
      acc = -693598668 + ((acc * x2) >>> 30);
      acc = 1686629713 + ((acc * x2) >>> 30);
      s = (acc * x) >>> 30;
      q = (s + 16384) >>> 15;
      return ph[31] ? -q : q;
    endfunction

    function longint series_q24(logic [31:0] ph);
      longint sum;
      logic [31:0] hp;
      sum = longint'(COEF_COS[0]) * 32768;
      for (int h = 1; h <= HARMONICS; h++) begin
        hp = ph * h;
        sum += longint'(COEF_COS[h]) * sine_q15(hp + 32'h4000_0000);
        sum += longint'(COEF_SIN[h]) * sine_q15(hp);
      end
      sum -= longint'(offset_deg) * 64'sd2147483648;
      return (sum * 1143819) >>> 23;
    endfunction

    function logic signed [15:0] to_mrad(longint q24);
      longint v;
      v = (q24 >= 0) ? (q24 >>> 24) : -((-q24) >>> 24);
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[15:0];
    endfunction

    function void note_tick(logic restart);
      longint right, left, w, st, tr, tl;
      logic [15:0] last_step;
      joint_cmd_t c;
      if (restart) begin
        stage = GAIT_HOMING; step_count = 0; homing_phase = 0; walk_phase = 0;
      end
      if (stage == GAIT_DONE) return;
      if (stage == GAIT_HOMING) begin
        w = 32768 + sine_q15(homing_phase + 32'h4000_0000);
        st = longint'(start_mrad) <<< 24;
        tr = series_q24(32'h0);
        tl = series_q24(32'h0 - left_lag);
        right = tr + (((st - tr) * w) >>> 16);
        left = tl + (((st - tl) * w) >>> 16);
        last_step = homing_last;
      end else begin
        right = series_q24(walk_phase);
        left = series_q24(walk_phase - left_lag);
        last_step = walk_last;
      end
      for (int j = 0; j < 2; j++) begin
        c.joint = j[0];
        c.target_mrad = to_mrad(j ? left : right);
        c.stage = (stage == GAIT_WALKING);
        c.step_index = step_count;
        c.last = j[0];
        pending_cmds.push_back(c);
      end
      if (step_count >= last_step || step_count == 16'hFFFF) begin
        stage = (stage == GAIT_HOMING) ? GAIT_WALKING : GAIT_DONE;
        step_count = 0; walk_phase = 0; homing_phase = 0;
      end else begin
        step_count++;
        if (stage == GAIT_HOMING) homing_phase += homing_inc;
        else walk_phase += walk_inc;
      end
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH %0t: %s got %0h expected %0h", $realtime, what, got, want);
      errors++;
    endtask

    task check_cmd(logic [31:0] data, logic [1:0] user, logic lst);
      joint_cmd_t c;
      if (pending_cmds.size() == 0) begin
        report("unexpected output transfer", data, 0);
        return;
      end
      c = pending_cmds.pop_front();
      if (user[0] !== c.joint) report("joint", user[0], c.joint);
      if (data[15:0] !== c.target_mrad) report("target_mrad", data[15:0], c.target_mrad);
      if (user[1] !== c.stage) report("stage", user[1], c.stage);
      if (data[31:16] !== c.step_index) report("step_index", data[31:16], c.step_index);
      if (lst !== c.last) report("last", lst, c.last);
    endtask
  endclass

  logic clk = 0, rst = 1;
  logic s_tvalid = 0, m_tready = 0, cfg_wen = 0;
  logic [7:0] s_tdata = 0;
  logic [2:0] cfg_index = 0;
  logic [31:0] cfg_data = 0;
  wire s_tready, m_tvalid, m_tlast;
  wire [31:0] m_tdata;
  wire [1:0] m_tuser;

  trajectory_scoreboard sb = new();
  int send_idle_pct = 0, recv_stall_pct = 0, hold_left = 0, quiet_cycles = 0;

  fourier_gait_trajectory_generator dut (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready,
    .m_tdata, .m_tuser, .m_tlast, .cfg_wen, .cfg_index, .cfg_data
  );

  always #4 clk = ~clk;

  always @(negedge clk) begin
    if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) sb.note_tick(s_tdata[0]);
    if (!rst && m_tvalid && m_tready) sb.check_cmd(m_tdata, m_tuser, m_tlast);
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_tick(logic restart);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {7'b0, restart};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_reg(logic [2:0] idx, logic [31:0] val);
    cfg_wen <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    sb.write_reg(idx, val);
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    cfg_wen <= 1'b0;
    while (sb.pending_cmds.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic load_all(int sp, logic [15:0] hs, logic [15:0] ws, logic [31:0] wi,
                          logic [31:0] hi, logic [31:0] lo, int od);
    set_reg(REG_START, sp);
    set_reg(REG_HSTEPS, hs);
    set_reg(REG_WSTEPS, ws);
    set_reg(REG_WINC, wi);
    set_reg(REG_HINC, hi);
    set_reg(REG_LOFF, lo);
    set_reg(REG_OFFSET, od);
    cfg_wen <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    sb.reset_state();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Defaults: three homing ticks, then a restart and one more tick.
    repeat (3) send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
    drain();

    // Zero last-step registers, lowest extremes: one tick per stage, then done.
    set_reg(REG_UNUSED, 32'hFFFF_FFFF);
    load_all(-6284, 0, 0, 32'h0, 32'h0, 32'h0, -180);
    for (int i = 0; i < 5; i++) send_tick(1'b0);
    send_tick(1'b1);
    repeat (3) send_tick(1'b0);
    drain();

    load_all(6284, 1, 2, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 180);
    send_tick(1'b1);
    repeat (7) send_tick(1'b0);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
        default: begin send_idle_pct = 23; recv_stall_pct = 23; end
      endcase
      if (ph == 5)
        load_all($urandom_range(12568) - 6284, 16'hFFFF, 16'hFFFF, $urandom, $urandom,
                 $urandom, $urandom_range(360) - 180);
      else
        load_all($urandom_range(12568) - 6284, $urandom_range(8), $urandom_range(12),
                 $urandom, $urandom, $urandom, $urandom_range(360) - 180);
      if (ph == 2) hold_left = HOLD_CYCLES;
      for (int i = 0; i < 215; i++) send_tick($urandom_range(14) == 0);
      drain();
    end

    if (sb.errors == 0 && sb.pending_cmds.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
